@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the scheduler.
// Depends on nothing; the using module provides i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define FPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// A stalled valid word keeps its valid and the given signal.
`define FPS_ASSERT_HOLD(lbl, vld, stl, sig, msg) \
    `FPS_ASSERT(lbl, (vld && stl) |=> (vld && $stable(sig)), msg)

`endif

@@ hw/rtl/fps_pkg.sv @@
// Shared types, codes and sizes of the frame presentation scheduler.
// Depends on nothing; used by every module of the block.
package fps_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [63:0] RESET_START    = 64'd0;
    localparam logic [31:0] RESET_INTERVAL = 32'd16666667;

    localparam logic [1:0] CFG_START_TIME       = 2'd0;
    localparam logic [1:0] CFG_INITIAL_INTERVAL = 2'd1;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_UPDATE  = 2'd1,
        CMD_RELEASE = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_ENCODE,
        S_MULTIPLY,
        S_APPLY
    } t_state;

    typedef struct packed {
        logic [31:0] id;
        logic [63:0] sched;
        logic        shown;
    } t_entry;

    typedef struct packed {
        logic load;
        logic shift;
        logic mark;
    } t_cell_ctrl;

    localparam t_entry ENTRY_BLANK = '{id: 32'd0, sched: 64'd0, shown: 1'b0};

endpackage

@@ hw/rtl/fps_cell.sv @@
// One queue slot: buffer id, requested time and presented mark.
// Depends on fps_pkg; instanced in a row by the top level.
module fps_cell
    import fps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cell_ctrl  i_ctrl,
    input  t_entry      i_load,
    input  t_entry      i_next,
    input  logic [31:0] i_key,
    input  logic        i_valid,
    output t_entry      o_entry,
    output logic        o_match,
    output logic        o_pending
);

    logic [31:0] r_id;
    logic [63:0] r_sched;
    logic        r_shown;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown <= 1'b0;
        end else begin
            priority if (i_ctrl.load) begin
                r_shown <= i_load.shown;
            end else if (i_ctrl.shift) begin
                r_shown <= i_next.shown;
            end else if (i_ctrl.mark) begin
                r_shown <= 1'b1;
            end else begin
                r_shown <= r_shown;
            end
        end
    end

    // Take a new word, or close up from the neighbour behind.
    always_ff @(posedge i_clk) begin
        priority if (i_ctrl.load) begin
            r_id    <= i_load.id;
            r_sched <= i_load.sched;
        end else if (i_ctrl.shift) begin
            r_id    <= i_next.id;
            r_sched <= i_next.sched;
        end else begin
            r_id    <= r_id;
            r_sched <= r_sched;
        end
    end

    assign o_entry   = '{id: r_id, sched: r_sched, shown: r_shown};
    assign o_match   = i_valid && (r_id == i_key);
    assign o_pending = i_valid && !r_shown;

endmodule

@@ hw/rtl/frame_presentation_scheduler_core.sv @@
// Top level of the frame presentation scheduler: command sequencer, row of cells.
// Depends on fps_pkg and fps_cell.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------------------------
//  command  | in        | i_in_valid/o_in_stall | i_command i_buffer_id i_shown_time
//           |           |                       | i_new_interval
//  result   | out       | o_out_valid/i_out_stall| o_status o_scheduled_time o_out_of_order
//  config   | in        | i_cfg_we              | i_cfg_index i_cfg_data
//
// Each command word is captured at acceptance and its result word is registered after
// id match across the cells, one-hot encode, the interval multiply, and the apply step
// with its 64-bit add and compare. The next command is taken the cycle after the apply
// step and not before, so commands do not overlap.
// Reset is synchronous and needs no clearing pass; occupancy follows the fill count.
// A stalled result word holds the apply step, and with it the command side.
module frame_presentation_scheduler_core
    import fps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_buffer_id,
    input  logic [63:0] i_shown_time,
    input  logic [31:0] i_new_interval,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [63:0] o_scheduled_time,
    output logic        o_out_of_order,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    // Sequencer state and captured command word.
    t_state r_state, n_state;
    logic [1:0]  r_command;
    logic [31:0] r_buffer_id;
    logic [63:0] r_shown_time;
    logic [31:0] r_new_interval;

    // Schedule state.
    logic [CNT_W-1:0] r_count;
    logic [63:0]      r_last;
    logic [31:0]      r_interval;

    // Per-command working registers.
    logic [QUEUE_DEPTH-1:0] r_hit, r_pend, r_therm;
    logic                   r_found, r_ooo, r_late;
    logic [CNT_W-1:0]       r_after;
    logic [63:0]            r_sel_sched;
    logic [31+CNT_W:0]      r_prod;

    // Result word.
    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [63:0] r_sched_out;
    logic        r_ooo_out;

    logic w_accept, w_out_free, w_apply;
    logic w_enq_ok, w_upd_ok, w_rel_ok;

    t_entry                 w_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_match, w_pending;
    t_entry                 w_load;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_MATCH;
            S_MATCH:    n_state = S_ENCODE;
            S_ENCODE:   n_state = S_MULTIPLY;
            S_MULTIPLY: n_state = S_APPLY;
            S_APPLY:    if (w_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        w_apply    = (r_state == S_APPLY) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_command      <= i_command;
            r_buffer_id    <= i_buffer_id;
            r_shown_time   <= i_shown_time;
            r_new_interval <= i_new_interval;
        end
    end

    // ---- row of cells ----
    assign w_enq_ok = (r_command == CMD_ENQUEUE) && !r_found
                      && (r_count < CNT_W'(QUEUE_DEPTH));
    assign w_upd_ok = (r_command == CMD_UPDATE) && (r_count != '0) && r_found;
    assign w_rel_ok = (r_command == CMD_RELEASE) && r_found;

    assign w_load = '{id: r_buffer_id, sched: r_last + 64'(r_interval), shown: 1'b0};

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_cell_ctrl w_ctrl;
        t_entry     w_next;

        assign w_ctrl = '{load:  w_apply && w_enq_ok && (r_count == CNT_W'(g)),
                          shift: w_apply && w_rel_ok && r_therm[g],
                          mark:  w_apply && w_upd_ok && r_hit[g]};

        if (g < QUEUE_DEPTH - 1) begin : g_inner
            assign w_next = w_entry[g + 1];
        end else begin : g_tail
            assign w_next = ENTRY_BLANK;
        end

        fps_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_load    (w_load),
            .i_next    (w_next),
            .i_key     (r_buffer_id),
            .i_valid   (CNT_W'(g) < r_count),
            .o_entry   (w_entry[g]),
            .o_match   (w_match[g]),
            .o_pending (w_pending[g])
        );
    end

    // ---- match, encode, multiply ----
    logic [IDX_W-1:0]       w_pos;
    logic [63:0]            w_sel_sched;
    logic [QUEUE_DEPTH-1:0] w_first_pend;
    logic [63:0]            w_diff;

    // At most one cell matches, so an OR over the hits encodes and selects.
    always_comb begin
        w_pos       = '0;
        w_sel_sched = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_pos       = w_pos | ({IDX_W{r_hit[i]}} & IDX_W'(i));
            w_sel_sched = w_sel_sched | ({64{r_hit[i]}} & w_entry[i].sched);
        end
    end

    assign w_first_pend = r_pend & (~r_pend + 1'b1);
    assign w_diff       = r_shown_time - r_sel_sched;

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_MATCH: begin
                r_hit  <= w_match;
                r_pend <= w_pending;
            end
            S_ENCODE: begin
                // Cells at and behind the hit close up on release.
                r_therm     <= ~r_hit + 1'b1;
                r_found     <= |r_hit;
                r_ooo       <= ((w_first_pend & r_hit) == '0);
                r_after     <= r_count - CNT_W'(w_pos) - 1'b1;
                r_sel_sched <= w_sel_sched;
            end
            S_MULTIPLY: begin
                r_prod <= r_interval * r_after;
                r_late <= (w_diff != '0) && !w_diff[63];
            end
            default: ;
        endcase
    end

    // ---- apply ----
    logic [63:0] w_cand;
    assign w_cand = r_shown_time + 64'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_last     <= RESET_START;
            r_interval <= RESET_INTERVAL;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_START_TIME) begin
                r_last <= i_cfg_data;
            end else if (i_cfg_index == CFG_INITIAL_INTERVAL) begin
                r_interval <= i_cfg_data[31:0];
            end
        end else if (w_apply) begin
            if (w_enq_ok) begin
                r_count <= r_count + 1'b1;
                r_last  <= w_load.sched;
            end
            if (w_rel_ok) begin
                r_count <= r_count - 1'b1;
            end
            if (w_upd_ok) begin
                // Push the schedule forward only for a late frame.
                if (r_late && (w_cand > r_last)) begin
                    r_last <= w_cand;
                end
                r_interval <= r_new_interval;
            end
        end
    end

    // ---- result word ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_apply) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_sched_out <= '0;
            r_ooo_out   <= 1'b0;
            unique case (r_command)
                CMD_ENQUEUE: begin
                    if (r_found) begin
                        r_status <= ST_DUPLICATE;
                    end else if (!w_enq_ok) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_status    <= ST_OK;
                        r_sched_out <= w_load.sched;
                    end
                end
                CMD_UPDATE: begin
                    if (r_count == '0) begin
                        r_status <= ST_EMPTY;
                    end else if (!r_found) begin
                        r_status <= ST_NOT_FOUND;
                    end else begin
                        r_status  <= ST_OK;
                        r_ooo_out <= r_ooo;
                    end
                end
                CMD_RELEASE: begin
                    r_status <= r_found ? ST_OK : ST_NOT_FOUND;
                end
                default: begin
                    r_status <= ST_OK;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_scheduled_time = r_sched_out;
    assign o_out_of_order   = r_ooo_out;

endmodule

@@ hw/rtl/fps_checker.sv @@
// Port-level checks of the frame presentation scheduler, bound to the top level.
// Depends on fps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fps_checker
    import fps_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_status,
    input logic [63:0] o_scheduled_time,
    input logic        o_out_of_order
);

    // A result word that reports a failure.
    logic w_fail;
    assign w_fail = o_out_valid && (o_status != ST_OK);

    `FPS_ASSERT_HOLD(a_out_hold, o_out_valid, i_out_stall, o_scheduled_time, "stalled word moved")
    `FPS_ASSERT(a_in_busy, (i_in_valid && !o_in_stall) |=> o_in_stall, "no stall after accept")
    `FPS_ASSERT(a_time_only_ok, w_fail |-> (o_scheduled_time == '0), "time on failed command")
    `FPS_ASSERT(a_ooo_only_ok, (o_out_valid && o_out_of_order) |-> !w_fail, "order flag on error")

endmodule

bind frame_presentation_scheduler_core fps_checker u_fps_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for frame_presentation_scheduler_core: directed table, then random traffic.
// Depends on fps_pkg and the scheduler RTL; a queue predictor or the table supplies the expected words.
module tb_top;
    import fps_pkg::*;

    localparam logic [1:0] CMD_UNUSED       = 2'd3;
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int         STALL_LIMIT      = 4000;
    localparam int         PHASE_ITEMS      = 280;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] sched_time;
        logic        out_of_order;
    } sched_result_t;

    typedef struct {
        logic [1:0]    cmd;
        logic [31:0]   id;
        logic [63:0]   shown;
        logic [31:0]   nint;
        bit            typed;
        sched_result_t want;
    } directed_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_command;
    logic [31:0] i_buffer_id;
    logic [63:0] i_shown_time;
    logic [31:0] i_new_interval;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [63:0] o_scheduled_time;
    logic        o_out_of_order;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    // Predictor copy of the schedule queue and its registers.
    logic [31:0] sched_ids   [QUEUE_DEPTH];
    logic [63:0] sched_times [QUEUE_DEPTH];
    bit          sched_shown [QUEUE_DEPTH];
    int          sched_count;
    logic [63:0] last_sched_time;
    logic [31:0] frame_interval_now;

    sched_result_t pending_results[$];
    directed_row_t directed_rows[$];

    int idle_pct;
    bit filling;
    int fail_count;
    int words_checked;
    int commands_sent;
    int quiet_cycles;
    int status_seen[8];
    int ooo_seen;

    frame_presentation_scheduler_core uut (.*);

    always #10 i_clk = ~i_clk;

    // Locate a queued buffer; QUEUE_DEPTH means absent.
    function automatic int find_buffer(logic [31:0] id);
        for (int i = 0; i < sched_count; i++) begin
            if (sched_ids[i] == id) return i;
        end
        return QUEUE_DEPTH;
    endfunction

    // Apply one command to the predicted queue and return the word it should produce.
    function automatic sched_result_t schedule_command(logic [1:0] cmd, logic [31:0] id,
                                                       logic [63:0] shown, logic [31:0] nint);
        sched_result_t res;
        int            pos;
        int            pending_pos;
        logic [63:0]   lateness;
        logic [63:0]   candidate;
        res = '0;
        res.status = ST_OK;
        case (cmd)
            CMD_ENQUEUE: begin
                if (find_buffer(id) < QUEUE_DEPTH) begin
                    res.status = ST_DUPLICATE;
                end else if (sched_count >= QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    last_sched_time = last_sched_time + {32'd0, frame_interval_now};
                    sched_ids[sched_count]   = id;
                    sched_times[sched_count] = last_sched_time;
                    sched_shown[sched_count] = 1'b0;
                    sched_count++;
                    res.sched_time = last_sched_time;
                end
            end
            CMD_UPDATE: begin
                pos = find_buffer(id);
                if (sched_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (pos >= QUEUE_DEPTH) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    pending_pos = QUEUE_DEPTH;
                    for (int i = sched_count - 1; i >= 0; i--) begin
                        if (!sched_shown[i]) pending_pos = i;
                    end
                    res.out_of_order = (pos != pending_pos);
                    // Late means a strictly positive signed distance from the requested time.
                    lateness  = shown - sched_times[pos];
                    candidate = shown + {32'd0, frame_interval_now} * 64'(sched_count - pos - 1);
                    if (lateness != 64'd0 && !lateness[63] && candidate > last_sched_time) begin
                        last_sched_time = candidate;
                    end
                    sched_shown[pos]   = 1'b1;
                    frame_interval_now = nint;
                end
            end
            CMD_RELEASE: begin
                pos = find_buffer(id);
                if (pos >= QUEUE_DEPTH) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    for (int i = pos; i + 1 < sched_count; i++) begin
                        sched_ids[i]   = sched_ids[i + 1];
                        sched_times[i] = sched_times[i + 1];
                        sched_shown[i] = sched_shown[i + 1];
                    end
                    sched_count--;
                    sched_shown[sched_count] = 1'b0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void add_row(logic [1:0] cmd, logic [31:0] id, logic [63:0] shown,
                                    logic [31:0] nint, bit typed, logic [2:0] st,
                                    logic [63:0] when, logic ooo);
        directed_row_t row;
        row.cmd                = cmd;
        row.id                 = id;
        row.shown              = shown;
        row.nint               = nint;
        row.typed              = typed;
        row.want.status        = st;
        row.want.sched_time    = when;
        row.want.out_of_order  = ooo;
        directed_rows = {directed_rows, row};
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH word %0d %s: got %h want %h", words_checked, what, got, want);
        fail_count++;
    endtask

    // Present one command word at the falling edge and hold it until taken.
    task automatic send_command(logic [1:0] cmd, logic [31:0] id, logic [63:0] shown,
                                logic [31:0] nint, bit typed, sched_result_t want);
        sched_result_t predicted;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_buffer_id    <= id;
        i_shown_time   <= shown;
        i_new_interval <= nint;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = schedule_command(cmd, id, shown, nint);
        if (typed) predicted = want;
        pending_results = {pending_results, predicted};
        commands_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every outstanding word is back and the pipe is empty.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] index, logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_START_TIME) begin
            last_sched_time = data;
        end else if (index == CFG_INITIAL_INTERVAL) begin
            frame_interval_now = data[31:0];
        end
        @(negedge i_clk);
    endtask

    // Mostly well-formed traffic: updates and releases aim at queued buffers, update times
    // sit around the requested time so that early, on-time and late all occur.
    task automatic random_command();
        logic [1:0]    cmd;
        logic [31:0]   id;
        logic [63:0]   shown;
        logic [31:0]   nint;
        logic [63:0]   span;
        logic [63:0]   spread;
        int            pick;
        int            pos;
        int            enq_weight;
        sched_result_t none;
        none       = '0;
        enq_weight = filling ? 60 : 25;
        pick       = $urandom_range(0, 99);
        id         = $urandom();
        shown      = {$urandom(), $urandom()};
        nint       = $urandom();
        if (pick < 3) begin
            cmd = CMD_UNUSED;
        end else if (pick < 3 + enq_weight) begin
            cmd = CMD_ENQUEUE;
            if (sched_count > 0 && $urandom_range(0, 99) < 12) begin
                id = sched_ids[$urandom_range(0, sched_count - 1)];
            end else if ($urandom_range(0, 99) < 15) begin
                id = $urandom_range(0, 31);
            end
        end else if (pick < 3 + enq_weight + (97 - enq_weight) * 6 / 10) begin
            cmd = CMD_UPDATE;
            if (sched_count > 0 && $urandom_range(0, 99) < 88) begin
                pos = $urandom_range(0, sched_count - 1);
                id  = sched_ids[pos];
                case ($urandom_range(0, 9))
                    0: ;
                    1: shown = sched_times[pos];
                    default: begin
                        span   = {32'd0, frame_interval_now} + 64'd1000;
                        spread = {$urandom(), $urandom()} % (3 * span + 1);
                        shown  = sched_times[pos] - span + spread;
                    end
                endcase
            end
            case ($urandom_range(0, 9))
                0: ;
                1: nint = 32'd0;
                default: nint = $urandom_range(16000000, 17500000);
            endcase
        end else begin
            cmd = CMD_RELEASE;
            if (sched_count > 0 && $urandom_range(0, 99) < 85) begin
                id = sched_ids[$urandom_range(0, sched_count - 1)];
            end
        end
        send_command(cmd, id, shown, nint, 1'b0, none);
    endtask

    // Receiver side: stall at random on the falling edge.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    // Check each accepted result word against the oldest expectation; watch for a hang.
    always @(posedge i_clk) begin
        sched_result_t want;
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected word", {61'd0, o_status}, 64'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", {61'd0, o_status}, {61'd0, want.status});
                    if (o_scheduled_time !== want.sched_time)
                        report_mismatch("scheduled_time", o_scheduled_time, want.sched_time);
                    if (o_out_of_order !== want.out_of_order)
                        report_mismatch("out_of_order", {63'd0, o_out_of_order},
                                        {63'd0, want.out_of_order});
                end
                if (o_status < 3'd5) status_seen[o_status]++;
                if (o_out_of_order === 1'b1) ooo_seen++;
                words_checked++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                         STALL_LIMIT, pending_results.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_command      = CMD_ENQUEUE;
        i_buffer_id    = '0;
        i_shown_time   = '0;
        i_new_interval = '0;
        i_out_stall    = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_START_TIME;
        i_cfg_data     = '0;
        idle_pct       = 38;
        filling        = 1'b1;
        fail_count     = 0;
        words_checked  = 0;
        commands_sent  = 0;
        quiet_cycles   = 0;
        ooo_seen       = 0;
        foreach (status_seen[i]) status_seen[i] = 0;

        last_sched_time      = RESET_START;
        frame_interval_now   = RESET_INTERVAL;
        sched_count          = 0;
        foreach (sched_shown[i]) sched_shown[i] = 1'b0;

        // Directed table, starting from the reset schedule (time 0, interval 16666667).
        add_row(CMD_UPDATE,  32'd5, 64'd0, 32'd0, 1, ST_EMPTY, 64'd0, 1'b0);
        add_row(CMD_RELEASE, 32'd5, 64'd0, 32'd0, 1, ST_NOT_FOUND, 64'd0, 1'b0);
        add_row(CMD_ENQUEUE, 32'd0, 64'd0, 32'd0, 1, ST_OK, 64'd16666667, 1'b0);
        add_row(CMD_ENQUEUE, 32'd0, 64'd0, 32'd0, 1, ST_DUPLICATE, 64'd0, 1'b0);
        add_row(CMD_ENQUEUE, 32'hFFFF_FFFF, 64'd0, 32'd0, 1, ST_OK, 64'd33333334, 1'b0);
        add_row(CMD_UPDATE,  32'd7, 64'd0, 32'd0, 1, ST_NOT_FOUND, 64'd0, 1'b0);
        // On time, but the head is still unpresented.
        add_row(CMD_UPDATE, 32'hFFFF_FFFF, 64'd33333334, 32'hFFFF_FFFF, 1, ST_OK, 64'd0, 1'b1);
        // Early by a wrapped distance, then late by one with nothing left unpresented.
        add_row(CMD_UPDATE, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 0, ST_OK, 64'd0, 1'b0);
        add_row(CMD_UPDATE, 32'd0, 64'd16666668, 32'd1, 0, ST_OK, 64'd0, 1'b0);
        add_row(CMD_UNUSED, 32'd0, 64'd0, 32'd0, 1, ST_OK, 64'd0, 1'b0);
        add_row(CMD_RELEASE, 32'd0, 64'd0, 32'd0, 1, ST_OK, 64'd0, 1'b0);
        add_row(CMD_RELEASE, 32'd0, 64'd0, 32'd0, 1, ST_NOT_FOUND, 64'd0, 1'b0);
        for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            add_row(CMD_ENQUEUE, 32'h100 + k, 64'd0, 32'd0, 0, ST_OK, 64'd0, 1'b0);
        end
        add_row(CMD_ENQUEUE, 32'hABCD, 64'd0, 32'd0, 1, ST_FULL, 64'd0, 1'b0);
        // Duplicate takes precedence over full.
        add_row(CMD_ENQUEUE, 32'hFFFF_FFFF, 64'd0, 32'd0, 1, ST_DUPLICATE, 64'd0, 1'b0);
        // Very late update in mid queue: pushes the schedule forward.
        add_row(CMD_UPDATE, 32'h105, 64'h7FFF_FFFF_FFFF_0000, 32'd16666667, 0, ST_OK, 64'd0,
                1'b0);
        add_row(CMD_RELEASE, 32'h103, 64'd0, 32'd0, 1, ST_OK, 64'd0, 1'b0);
        add_row(CMD_ENQUEUE, 32'h200, 64'd0, 32'd0, 0, ST_OK, 64'd0, 1'b0);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            send_command(directed_rows[r].cmd, directed_rows[r].id, directed_rows[r].shown,
                         directed_rows[r].nint, directed_rows[r].typed, directed_rows[r].want);
        end

        for (int phase = 0; phase < 4; phase++) begin
            if (phase > 0) begin
                drain_results();
                case (phase)
                    1: begin
                        // Top extremes: times wrap almost at once; upper data bits ignored.
                        cfg_write(CFG_START_TIME, 64'hFFFF_FFFF_FFFF_FF00);
                        cfg_write(CFG_INITIAL_INTERVAL, {32'hDEAD_BEEF, 32'hFFFF_FFFF});
                        cfg_write(CFG_UNUSED_INDEX, {$urandom(), $urandom()});
                    end
                    2: begin
                        cfg_write(CFG_START_TIME, 64'd0);
                        cfg_write(CFG_INITIAL_INTERVAL, 64'd0);
                    end
                    default: begin
                        cfg_write(CFG_START_TIME, {$urandom(), $urandom()});
                        cfg_write(CFG_INITIAL_INTERVAL, {$urandom(), 32'd16666667});
                    end
                endcase
            end
            // Run phase two flat out on both sides.
            idle_pct = (phase == 2) ? 0 : 38;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 60 == 0) filling = ~filling;
                if (phase == 1 && k == PHASE_ITEMS / 2) drain_results();
                random_command();
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d commands, %0d result words: ok %0d, empty %0d, not found %0d, dup %0d",
                 commands_sent, words_checked, status_seen[ST_OK], status_seen[ST_EMPTY],
                 status_seen[ST_NOT_FOUND], status_seen[ST_DUPLICATE]);
        $display("full %0d, out of order %0d, over four schedule settings; %0d mismatches",
                 status_seen[ST_FULL], ooo_seen, fail_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
